[rtl/hbsa_pkg.sv]
// Package for the hierarchical bitmap slot allocator.
// Operation and status codes shared by the allocator files; no dependencies.
package hbsa_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC_ANY  = 2'd0,
        OP_ALLOC_SLOT = 2'd1,
        OP_FREE_SLOT  = 2'd2,
        OP_FREE_OFF   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_TAKEN = 3'd2,
        ST_RANGE = 3'd3,
        ST_ALIGN = 3'd4
    } status_t;

    localparam int STRIDE_W  = 16;
    localparam int OFFSET_W  = 32;
    localparam int SLOT_IN_W = 12;
    localparam int GOFF_W    = 28;
    localparam int COUNT_W   = 13;

endpackage

[rtl/hierarchical_bitmap_slot_allocator.sv]
// Hierarchical bitmap slot allocator: top level with sequencer, bitmap memory
// and shared shift-subtract divider / shift-add multiplier. Uses hbsa_pkg.
//
// Pool allocator over POOL_SLOTS slots kept as a leaf bitmap of WORD_BITS-bit
// words (one memory, one read and one write port) plus a summary register with
// one bit per leaf word that marks full words. Allocate-any finds the lowest
// zero in the summary, then the lowest zero in that leaf word. One item is in
// flight at a time: allocate and free by slot go through a summary check, leaf
// read, leaf write-back (skipped on an error), then a 16-step shift-add
// multiply for the byte offset; free by byte offset adds a 32-step restoring
// division by the configured stride first. The result is held in an output
// register until taken; the next item is accepted once the result is taken
// and the sequencer is back in idle.
module hierarchical_bitmap_slot_allocator
    import hbsa_pkg::*;
#(
    parameter int WORD_BITS  = 64,
    parameter int POOL_SLOTS = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [STRIDE_W-1:0]  cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_operation,
    input  logic [SLOT_IN_W-1:0] s_slot,
    input  logic [OFFSET_W-1:0]  s_byte_offset,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [SLOT_IN_W-1:0] m_granted_slot,
    output logic [GOFF_W-1:0]    m_granted_offset,
    output logic [COUNT_W-1:0]   m_in_use
);

    localparam int LEAF_WORDS = POOL_SLOTS / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int LW_W       = (LEAF_WORDS > 1) ? $clog2(LEAF_WORDS) : 1;
    localparam int SLOT_W     = $clog2(POOL_SLOTS) + 1;  // holds POOL_SLOTS too
    localparam int DIV_W      = OFFSET_W;
    localparam int CNT_W      = $clog2(DIV_W) + 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DIV   = 8'b0000_0010,
        S_CHECK = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_LEAF  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_WAIT  = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [STRIDE_W-1:0]  stride_reg;
    logic [1:0]           op_reg;
    logic [SLOT_W-1:0]    slot_reg;
    status_t              status_reg;
    logic [LEAF_WORDS-1:0] summary_reg;
    logic [COUNT_W-1:0]   used_reg;
    // divider: remainder / quotient shift pair
    logic [DIV_W-1:0]     quo_reg;
    logic [STRIDE_W:0]    rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    // multiplier accumulator
    logic [GOFF_W-1:0]    acc_reg;
    logic                 out_valid_reg;
    logic [2:0]           out_status_reg;
    logic [SLOT_IN_W-1:0] out_slot_reg;
    logic [GOFF_W-1:0]    out_off_reg;
    logic [COUNT_W-1:0]   out_used_reg;

    // leaf bitmap memory
    logic [WORD_BITS-1:0] leaf_mem [LEAF_WORDS];
    logic [WORD_BITS-1:0] leaf_rd_reg;
    logic [LEAF_WORDS-1:0] leaf_vld_reg;   // cleared at reset, word reads as zero
    logic                 leaf_we;
    logic [LW_W-1:0]      leaf_waddr;
    logic [WORD_BITS-1:0] leaf_wdata;
    logic                 rd_vld_reg;
    logic [WORD_BITS-1:0] leaf_word;

    logic                 accept;
    logic [LW_W-1:0]      slot_lw;
    logic [BIT_W-1:0]     slot_bit;
    logic [LW_W-1:0]      free_lw;
    logic                 sum_full;
    logic [BIT_W-1:0]     free_bit;
    logic [STRIDE_W:0]    rem_shift;
    logic [STRIDE_W:0]    rem_diff;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign slot_lw  = LW_W'(slot_reg >> BIT_W);
    assign slot_bit = slot_reg[BIT_W-1:0];
    assign leaf_word = rd_vld_reg ? leaf_rd_reg : '0;

    // first zero in summary
    always_comb begin
        free_lw  = '0;
        sum_full = 1'b1;
        for (int i = LEAF_WORDS - 1; i >= 0; i--) begin
            if (!summary_reg[i]) begin
                free_lw  = LW_W'(i);
                sum_full = 1'b0;
            end
        end
    end

    // first zero in leaf word
    always_comb begin
        free_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!leaf_word[i]) free_bit = BIT_W'(i);
        end
    end

    // one restoring division step
    assign rem_shift = {rem_reg[STRIDE_W-1:0], quo_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, stride_reg};

    // leaf memory
    always_ff @(posedge aclk) begin
        if (leaf_we) leaf_mem[leaf_waddr] <= leaf_wdata;
        leaf_rd_reg <= leaf_mem[slot_lw];
    end

    always_comb begin
        state_next = state_reg;
        leaf_we    = 1'b0;
        leaf_waddr = slot_lw;
        leaf_wdata = leaf_word;
        case (state_reg)
            S_IDLE:  if (accept) begin
                case (op_t'(s_operation))
                    OP_FREE_OFF: state_next = S_DIV;
                    OP_ALLOC_ANY: state_next = S_CHECK;
                    default:     state_next = S_CHECK;
                endcase
            end
            S_DIV:   if (cnt_reg == CNT_W'(DIV_W)) state_next = S_CHECK;
            S_CHECK: state_next = (status_reg == ST_OK) ? S_READ : S_MUL;
            S_READ:  state_next = S_LEAF;
            S_LEAF: begin
                state_next = S_MUL;
                if (status_reg == ST_OK) begin
                    leaf_we = (op_reg != OP_ALLOC_SLOT) || !leaf_word[slot_bit]
                              || (op_reg == OP_ALLOC_ANY);
                    if (op_reg == OP_ALLOC_ANY)
                        leaf_wdata = leaf_word | (WORD_BITS'(1) << free_bit);
                    else if (op_reg == OP_ALLOC_SLOT)
                        leaf_wdata = leaf_word | (WORD_BITS'(1) << slot_bit);
                    else
                        leaf_wdata = leaf_word & ~(WORD_BITS'(1) << slot_bit);
                end
            end
            S_MUL:   if (cnt_reg == CNT_W'(STRIDE_W)) state_next = S_OUT;
            S_OUT:   state_next = S_WAIT;
            S_WAIT:  if (!out_valid_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            stride_reg    <= STRIDE_W'(8);
            summary_reg   <= '0;
            used_reg      <= '0;
            leaf_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) stride_reg <= cfg_wdata;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            rd_vld_reg <= leaf_vld_reg[slot_lw];
            case (state_reg)
                S_IDLE: if (accept) begin
                    op_reg     <= s_operation;
                    slot_reg   <= SLOT_W'(s_slot);
                    status_reg <= ST_OK;
                    quo_reg    <= s_byte_offset;
                    rem_reg    <= '0;
                    cnt_reg    <= '0;
                end
                S_DIV: if (cnt_reg != CNT_W'(DIV_W)) begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (!rem_diff[STRIDE_W]) begin
                        rem_reg <= rem_diff;
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                    end
                end else begin
                    if (stride_reg == '0 || rem_reg != '0)
                        status_reg <= ST_ALIGN;
                    else if (quo_reg >= DIV_W'(POOL_SLOTS))
                        status_reg <= ST_RANGE;
                    else
                        slot_reg <= SLOT_W'(quo_reg);
                end
                S_CHECK: begin
                    cnt_reg <= '0;
                    if (op_reg == OP_ALLOC_ANY) begin
                        if (sum_full) status_reg <= ST_FULL;
                        else slot_reg <= SLOT_W'({free_lw, {BIT_W{1'b0}}});
                    end else if (op_reg != OP_FREE_OFF
                                 && slot_reg >= SLOT_W'(POOL_SLOTS)) begin
                        status_reg <= ST_RANGE;
                    end
                end
                S_LEAF: if (status_reg == ST_OK) begin
                    if (op_reg == OP_ALLOC_ANY) begin
                        slot_reg[BIT_W-1:0] <= free_bit;
                        leaf_vld_reg[slot_lw] <= 1'b1;
                        used_reg <= used_reg + 1'b1;
                        if ((leaf_word | (WORD_BITS'(1) << free_bit)) == '1)
                            summary_reg[slot_lw] <= 1'b1;
                    end else if (op_reg == OP_ALLOC_SLOT) begin
                        if (leaf_word[slot_bit]) begin
                            status_reg <= ST_TAKEN;
                        end else begin
                            leaf_vld_reg[slot_lw] <= 1'b1;
                            used_reg <= used_reg + 1'b1;
                            if ((leaf_word | (WORD_BITS'(1) << slot_bit)) == '1)
                                summary_reg[slot_lw] <= 1'b1;
                        end
                    end else begin
                        leaf_vld_reg[slot_lw] <= 1'b1;
                        summary_reg[slot_lw]  <= 1'b0;
                        if (leaf_word[slot_bit] && used_reg != '0)
                            used_reg <= used_reg - 1'b1;
                    end
                    acc_reg <= '0;
                end else begin
                    acc_reg <= '0;
                end
                S_MUL: begin
                    if (cnt_reg == '0) begin
                        acc_reg <= '0;
                    end
                    if (cnt_reg != CNT_W'(STRIDE_W)) begin
                        cnt_reg <= cnt_reg + 1'b1;
                        // shift-add, multiplier bits MSB first
                        if (status_reg == ST_OK
                            && stride_reg[STRIDE_W-1-cnt_reg[CNT_W-2:0]])
                            acc_reg <= GOFF_W'({acc_reg, 1'b0})
                                       + GOFF_W'(slot_reg);
                        else
                            acc_reg <= GOFF_W'({acc_reg, 1'b0});
                    end
                end
                S_OUT: begin
                    out_valid_reg  <= 1'b1;
                    out_status_reg <= status_reg;
                    out_slot_reg   <= (status_reg == ST_OK) ? SLOT_IN_W'(slot_reg) : '0;
                    out_off_reg    <= (status_reg == ST_OK) ? acc_reg : '0;
                    out_used_reg   <= used_reg;
                end
                default: ;
            endcase
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_granted_slot   = out_slot_reg;
    assign m_granted_offset = out_off_reg;
    assign m_in_use         = out_used_reg;

    // a result never shows while an item is being accepted
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("result overlaps new item");
    // count never exceeds pool size
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= COUNT_W'(POOL_SLOTS)) else $error("in_use overflow");
    // error results carry zero slot
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_granted_slot == '0))
        else $error("error result with nonzero slot");

endmodule
